// ===== sv/dsda_pkg.sv =====
// ----------------------------------------------------------------------------
// Date serial arithmetic package
// Shared types, calendar tables and small helper functions for the date
// serial day pipeline.
// ----------------------------------------------------------------------------
package dsda_pkg;

   localparam int BASE_YEAR     = 1900;
   localparam int YEAR_SPAN_DEF = 256;

   // Leap days counted through 1899 by the 4/100/400 rule.
   localparam int LEAPS_BASE    = 460;

   // Width of the raw serial computed from a 12-bit year.
   localparam int RAW_W         = 21;
   localparam int RAW_DIGITS    = RAW_W / 3;

   // Years up to 9999 fit in this width.
   localparam int YR_W          = 14;
   localparam int DOY_W         = 9;
   localparam int Q100_W        = 7;

   // floor(q / 25) for q below 4096 as (q * DIV25_MUL) >> DIV25_SHIFT.
   localparam int DIV25_MUL     = 1311;
   localparam int DIV25_MUL_W   = 11;
   localparam int DIV25_SHIFT   = 15;

   // Year estimate: floor((n + bias) * 400 / 146097) through a reciprocal.
   localparam int     YEAR_RECIP_SHIFT = 24;
   localparam int     YEAR_RECIP_W     = 16;
   localparam longint YEAR_RECIP       =
      ((longint'(1) << YEAR_RECIP_SHIFT) * 400 + 146096) / 146097;
   localparam int     YEAR_EST_BIAS    = 2;

   localparam logic [4:0] MONTH_LEN [16] = '{
      5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
      5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
   };

   // Days before the first of each month in a common year.
   localparam logic [8:0] MONTH_START [16] = '{
      9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
      9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd0, 9'd0, 9'd0
   };

   typedef struct packed {
      logic [4:0]         day;
      logic [3:0]         month;
      logic [11:0]        year;
      logic signed [15:0] offset_days;
   } dsda_req_type;

   typedef struct packed {
      logic        valid_res;
      logic [16:0] serial_day;
      logic [2:0]  weekday;
      logic [4:0]  result_day;
      logic [3:0]  result_month;
      logic [11:0] result_year;
      logic        range_error;
   } dsda_rsp_type;

   // floor(y / 100) for y below 12800, done as floor(floor(y / 4) / 25).
   function automatic logic [Q100_W-1:0] div100(input logic [YR_W-1:0] y);
      logic [YR_W-3:0]             q4;
      logic [YR_W-2+DIV25_MUL_W:0] prod;
      q4   = y[YR_W-1:2];
      prod = (YR_W-1+DIV25_MUL_W)'(q4) * (YR_W-1+DIV25_MUL_W)'(DIV25_MUL);
      return prod[DIV25_SHIFT +: Q100_W];
   endfunction

   // Gregorian leap test given the year and floor(year / 100).
   function automatic logic is_leap(input logic [YR_W-1:0] y,
                                    input logic [Q100_W-1:0] q100);
      return (y[1:0] == 2'd0) &&
             ((y != YR_W'(q100 * 100)) || (q100[1:0] == 2'd0));
   endfunction

   // Remainder modulo 7 by summing octal digits, since 8 is 1 modulo 7.
   function automatic logic [2:0] mod7(input logic [RAW_W-1:0] x);
      logic [5:0] acc;
      logic [3:0] fold;
      logic [3:0] fin;
      acc = '0;
      for (int i = 0; i < RAW_DIGITS; i++) begin
         acc = acc + 6'(x[3*i +: 3]);
      end
      fold = 4'(acc[5:3]) + 4'(acc[2:0]);
      fin  = 4'(fold[3]) + 4'(fold[2:0]);
      return (fin == 4'd7) ? 3'd0 : fin[2:0];
   endfunction

endpackage

// ===== sv/date_serial_day_arithmetic.sv =====
// ----------------------------------------------------------------------------
// Date serial day arithmetic
// Checks a Gregorian date, gives its serial day (1900-01-01 is day 1) and
// weekday, and converts the serial plus a signed offset back to a date.
// ----------------------------------------------------------------------------
// The block is a nine-stage pipeline that accepts one date transaction per
// clock while the output is not stalled and returns its result from the last
// stage. The depth is set by the reverse conversion: a reciprocal multiply
// estimates the year, the start of that year is rebuilt and compared to pick
// the right year, and the month is found by comparing against the month
// start table. Each stage holds its transaction while the next stage is
// full and stalled, so bubbles are absorbed and a new transaction is taken
// while a finished result waits at the output. Invalid dates return all
// zeros; shifted dates outside years 1900 to 1900 + YEAR_SPAN - 1 are
// clamped to the first or last day and flag range_error.
module date_serial_day_arithmetic
   import dsda_pkg::*;
#(
   parameter int YEAR_SPAN = YEAR_SPAN_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  dsda_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output dsda_rsp_type rsp_data
);

   localparam int NUM_ST      = 9;
   localparam int LAST_YEAR   = BASE_YEAR + YEAR_SPAN - 1;
   localparam int LAST_SERIAL = 365 * YEAR_SPAN
                                + (LAST_YEAR / 4 - LAST_YEAR / 100 + LAST_YEAR / 400)
                                - LEAPS_BASE;
   localparam int SER_W       = $clog2(LAST_SERIAL + 1);
   localparam int SUM_W       = ((RAW_W > SER_W) ? RAW_W : SER_W) + 2;
   localparam int NW          = $clog2(LAST_SERIAL);
   localparam int BW          = SER_W;
   localparam int EW          = $clog2(YEAR_SPAN + 1);
   localparam int PW          = NW + 1 + YEAR_RECIP_W;

   typedef struct packed {
      logic        ok;
      logic [16:0] serial;
      logic [2:0]  wd;
      logic        rerr;
   } carry_type;

   logic [NUM_ST:1] v_ff;
   logic [NUM_ST:1] adv;

   // Stage registers.
   dsda_req_type      s1_req_ff;
   logic [Q100_W-1:0] s1_q100y_ff, s1_q100n_ff;
   logic              s1_yok_ff;

   logic              s2_ok_ff;
   logic [RAW_W-1:0]  s2_serial_ff;
   logic signed [15:0] s2_off_ff;

   carry_type         s3_c_ff, s4_c_ff, s5_c_ff, s6_c_ff, s7_c_ff, s8_c_ff;
   logic [NW-1:0]     s3_n_ff, s4_n_ff, s5_n_ff, s6_n_ff;
   logic [EW-1:0]     s4_e_ff, s5_e_ff, s6_e_ff;
   logic [YR_W-1:0]   s5_m_ff;
   logic [Q100_W-1:0] s5_qa_ff, s5_qb_ff;
   logic [BW-1:0]     s6_b_ff;
   logic              s6_leapa_ff, s6_leapb_ff;
   logic [EW-1:0]     s7_yoff_ff, s8_yoff_ff;
   logic [DOY_W-1:0]  s7_doy_ff, s8_doy_ff;
   logic              s7_leap_ff, s8_leap_ff;
   logic [3:0]        s8_month_ff;
   dsda_rsp_type      rsp_ff;

   // Next values.
   logic [YR_W-1:0]   s1_yr;
   logic [Q100_W-1:0] s1_q100y_in, s1_q100n_in;
   logic              s1_yok_in;
   logic              s2_leap, s2_ok_in;
   logic [4:0]        s2_mlen;
   logic [31:0]       s2_ser_full;
   logic signed [SUM_W-1:0] s3_sum;
   logic [NW-1:0]     s3_n_in;
   logic              s3_rerr_in;
   logic [PW-1:0]     s4_prod;
   logic [YR_W-1:0]   s5_m_in;
   logic [31:0]       s6_b_full;
   logic [EW-1:0]     s7_yoff_in;
   logic [DOY_W-1:0]  s7_doy_in;
   logic              s7_leap_in;
   logic [3:0]        s8_month_in;
   logic [8:0]        s9_start;
   dsda_rsp_type      rsp_in;

   // A stage may load when it is empty or its contents move on.
   always_comb begin
      adv[NUM_ST] = !v_ff[NUM_ST] || !rsp_stall;
      for (int i = NUM_ST - 1; i >= 1; i--) begin
         adv[i] = !v_ff[i] || adv[i+1];
      end
   end

   assign req_stall = !adv[1];
   assign rsp_valid = v_ff[NUM_ST];
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[1]) begin
            v_ff[1] <= req_valid;
         end
         for (int i = 2; i <= NUM_ST; i++) begin
            if (adv[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   // Stage 1: century quotients of the year and of the year before.
   always_comb begin
      s1_yr       = YR_W'(req_data.year);
      s1_q100y_in = div100(s1_yr);
      s1_q100n_in = div100(YR_W'(s1_yr - YR_W'(1)));
      s1_yok_in   = (32'(req_data.year) >= BASE_YEAR) &&
                    (32'(req_data.year) <= LAST_YEAR);
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_req_ff   <= req_data;
         s1_q100y_ff <= s1_q100y_in;
         s1_q100n_ff <= s1_q100n_in;
         s1_yok_ff   <= s1_yok_in;
      end
   end

   // Stage 2: validity check and forward serial.
   always_comb begin
      s2_leap  = is_leap(YR_W'(s1_req_ff.year), s1_q100y_ff);
      s2_mlen  = MONTH_LEN[s1_req_ff.month]
                 + 5'((s1_req_ff.month == 4'd2) && s2_leap);
      s2_ok_in = s1_yok_ff && (s1_req_ff.day != 5'd0) && (s1_req_ff.day <= s2_mlen);
      s2_ser_full = 32'(s1_req_ff.year) * 32'd365 - 32'(BASE_YEAR * 365)
                    + 32'(12'(s1_req_ff.year - 12'd1) >> 2)
                    - 32'(s1_q100n_ff) + 32'(s1_q100n_ff >> 2)
                    - 32'(LEAPS_BASE)
                    + 32'(MONTH_START[s1_req_ff.month])
                    + 32'(s2_leap && (s1_req_ff.month > 4'd2))
                    + 32'(s1_req_ff.day);
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s2_ok_ff     <= s2_ok_in;
         s2_serial_ff <= RAW_W'(s2_ser_full);
         s2_off_ff    <= s1_req_ff.offset_days;
      end
   end

   // Stage 3: add the offset, clamp to the supported range, weekday.
   always_comb begin
      s3_sum = SUM_W'($signed({1'b0, s2_serial_ff})) + SUM_W'(s2_off_ff);
      priority if (s3_sum < SUM_W'(1)) begin
         s3_n_in    = '0;
         s3_rerr_in = 1'b1;
      end else if (s3_sum > SUM_W'(LAST_SERIAL)) begin
         s3_n_in    = NW'(LAST_SERIAL - 1);
         s3_rerr_in = 1'b1;
      end else begin
         s3_n_in    = NW'(s3_sum - SUM_W'(1));
         s3_rerr_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s3_c_ff.ok     <= s2_ok_ff;
         s3_c_ff.serial <= s2_serial_ff[16:0];
         s3_c_ff.wd     <= mod7(RAW_W'(s2_serial_ff - RAW_W'(1)));
         s3_c_ff.rerr   <= s3_rerr_in;
         s3_n_ff        <= s3_n_in;
      end
   end

   // Stage 4: year estimate, equal to the true year offset or one above it.
   assign s4_prod = (PW'(s3_n_ff) + PW'(YEAR_EST_BIAS)) * PW'(YEAR_RECIP);

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s4_c_ff <= s3_c_ff;
         s4_n_ff <= s3_n_ff;
         s4_e_ff <= s4_prod[YEAR_RECIP_SHIFT +: EW];
      end
   end

   // Stage 5: century quotients of the estimated year and the one before.
   assign s5_m_in = YR_W'(BASE_YEAR - 1) + YR_W'(s4_e_ff);

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         s5_c_ff  <= s4_c_ff;
         s5_n_ff  <= s4_n_ff;
         s5_e_ff  <= s4_e_ff;
         s5_m_ff  <= s5_m_in;
         s5_qa_ff <= div100(s5_m_in);
         s5_qb_ff <= div100(YR_W'(s5_m_in + YR_W'(1)));
      end
   end

   // Stage 6: days before the estimated year.
   assign s6_b_full = 32'd365 * 32'(s5_e_ff) + 32'(s5_m_ff >> 2)
                      - 32'(s5_qa_ff) + 32'(s5_qa_ff >> 2) - 32'(LEAPS_BASE);

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         s6_c_ff     <= s5_c_ff;
         s6_n_ff     <= s5_n_ff;
         s6_e_ff     <= s5_e_ff;
         s6_b_ff     <= BW'(s6_b_full);
         s6_leapa_ff <= is_leap(s5_m_ff, s5_qa_ff);
         s6_leapb_ff <= is_leap(YR_W'(s5_m_ff + YR_W'(1)), s5_qb_ff);
      end
   end

   // Stage 7: correct the estimate and form the day of the year.
   always_comb begin
      if (32'(s6_n_ff) < 32'(s6_b_ff)) begin
         s7_yoff_in = EW'(s6_e_ff - EW'(1));
         s7_doy_in  = DOY_W'(32'(s6_n_ff) + 32'd365 + 32'(s6_leapa_ff) - 32'(s6_b_ff));
         s7_leap_in = s6_leapa_ff;
      end else begin
         s7_yoff_in = s6_e_ff;
         s7_doy_in  = DOY_W'(32'(s6_n_ff) - 32'(s6_b_ff));
         s7_leap_in = s6_leapb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         s7_c_ff    <= s6_c_ff;
         s7_yoff_ff <= s7_yoff_in;
         s7_doy_ff  <= s7_doy_in;
         s7_leap_ff <= s7_leap_in;
      end
   end

   // Stage 8: month search over the month start table.
   always_comb begin
      logic [8:0] st;
      s8_month_in = 4'd1;
      for (int k = 2; k <= 12; k++) begin
         st = MONTH_START[4'(k)] + 9'(s7_leap_ff && (k > 2));
         if (9'(s7_doy_ff) >= st) begin
            s8_month_in = 4'(k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[8]) begin
         s8_c_ff     <= s7_c_ff;
         s8_yoff_ff  <= s7_yoff_ff;
         s8_doy_ff   <= s7_doy_ff;
         s8_leap_ff  <= s7_leap_ff;
         s8_month_ff <= s8_month_in;
      end
   end

   // Stage 9: day of month and result formatting.
   always_comb begin
      s9_start = MONTH_START[s8_month_ff] + 9'(s8_leap_ff && (s8_month_ff > 4'd2));
      rsp_in   = '0;
      if (s8_c_ff.ok) begin
         rsp_in.valid_res    = 1'b1;
         rsp_in.serial_day   = s8_c_ff.serial;
         rsp_in.weekday      = s8_c_ff.wd;
         rsp_in.result_day   = 5'(9'(s8_doy_ff) - s9_start + 9'd1);
         rsp_in.result_month = s8_month_ff;
         rsp_in.result_year  = 12'(32'(BASE_YEAR) + 32'(s8_yoff_ff));
         rsp_in.range_error  = s8_c_ff.rerr;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[9]) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
